FILE: hdl/obb_separating_axis_overlap_assert.svh
// Assertion macros for the box overlap block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef OBB_SEPARATING_AXIS_OVERLAP_ASSERT_SVH
`define OBB_SEPARATING_AXIS_OVERLAP_ASSERT_SVH

// checked outside reset only
`define OBB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define OBB_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/obb_pkg.sv
// Shared constants and types for the oriented box overlap block.
// No dependencies.
package obb_pkg;

    localparam int COORD_WIDTH = 20;
    localparam int AXIS_WIDTH  = 16;

    localparam int STAGES    = 7;
    localparam int NUM_AXES  = 15;
    localparam int REG_IDX_W = 3;
    localparam int OUT_W     = 8;

    localparam logic [REG_IDX_W-1:0] REG_DIMENSION_MODE   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REF_CENTER       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REF_AXIS_U       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REF_AXIS_V       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REF_AXIS_W       = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_REF_HALF_EXTENTS = 3'd5;

    // axes tested in 2D: ref u,v; cand u,v; the four cross axes of u,v
    localparam logic [NUM_AXES-1:0] MASK_2D = 15'h06DB;
    localparam logic [NUM_AXES-1:0] MASK_3D = 15'h7FFF;

    typedef struct packed {
        logic [STAGES:1] adv;
    } obb_ctl_t;

endpackage

FILE: hdl/obb_separating_axis_overlap.sv
// Oriented box overlap by the separating axis test, one candidate box per
// request. A new request is taken every cycle while the result side keeps
// up; all 15 axis tests run in parallel lanes through the seven-stage
// multiplier pipeline.
// A stalled result stage holds and backs requests up through the pipeline.
// Depends on obb_pkg, obb_cross and obb_axis.
module obb_separating_axis_overlap #(
    parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH,
    parameter int AXIS_WIDTH  = obb_pkg::AXIS_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic [obb_pkg::REG_IDX_W-1:0]          cfg_index,
    input  logic [3*((COORD_WIDTH > AXIS_WIDTH) ? COORD_WIDTH : AXIS_WIDTH)-1:0] cfg_data,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // cand_center, cand_axis_u, cand_axis_v, cand_axis_w, cand_half_extents
    input  logic [((6*COORD_WIDTH + 9*AXIS_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // boxes_overlap, zero fill
    output logic [obb_pkg::OUT_W-1:0]              m_axis_tdata
);
    localparam int C     = COORD_WIDTH;
    localparam int A     = AXIS_WIDTH;
    localparam int PW    = A + 3;
    localparam int DW    = C + 1;
    localparam int NST   = obb_pkg::STAGES;
    localparam int NAX   = obb_pkg::NUM_AXES;
    localparam int CEN_LO = 0;
    localparam int AX_LO  = 3 * C;
    localparam int HLF_LO = 3 * C + 9 * A;

    // configuration
    logic           dim_mode_reg;
    logic [3*C-1:0] ref_center_reg;
    logic [3*A-1:0] ref_axis_reg [3];
    logic [3*C-1:0] ref_half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_mode_reg   <= 1'b1;
            ref_center_reg <= '0;
            ref_axis_reg   <= '{default: '0};
            ref_half_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                obb_pkg::REG_DIMENSION_MODE:   dim_mode_reg    <= cfg_data[0];
                obb_pkg::REG_REF_CENTER:       ref_center_reg  <= cfg_data[3*C-1:0];
                obb_pkg::REG_REF_AXIS_U:       ref_axis_reg[0] <= cfg_data[3*A-1:0];
                obb_pkg::REG_REF_AXIS_V:       ref_axis_reg[1] <= cfg_data[3*A-1:0];
                obb_pkg::REG_REF_AXIS_W:       ref_axis_reg[2] <= cfg_data[3*A-1:0];
                obb_pkg::REG_REF_HALF_EXTENTS: ref_half_reg    <= cfg_data[3*C-1:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic [NST:1]      valid_reg;
    logic [NST:1]      valid_next;
    obb_pkg::obb_ctl_t ctl;

    always_comb
    begin
        ctl.adv[NST] = !valid_reg[NST] || m_axis_tready;
        for (int k = NST - 1; k >= 1; k--)
        begin
            ctl.adv[k] = !valid_reg[k] || ctl.adv[k + 1];
        end
        for (int k = 1; k <= NST; k++)
        begin
            if (ctl.adv[k])
                valid_next[k] = (k == 1) ? s_axis_tvalid : valid_reg[k - 1];
            else
                valid_next[k] = valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign s_axis_tready = ctl.adv[1];

    // unpack and mask the request
    logic                 flat_in;
    logic signed [C-1:0]  rc;
    logic signed [C-1:0]  cc;
    logic signed [DW-1:0] d_in [3];
    logic signed [A-1:0]  ax_in [6][3];
    logic        [C-1:0]  half_in [6];

    always_comb
    begin
        flat_in = !dim_mode_reg;
        rc = '0;
        cc = '0;
        for (int i = 0; i < 3; i++)
        begin
            rc = ref_center_reg[i*C +: C];
            cc = s_axis_tdata[CEN_LO + i*C +: C];
            d_in[i] = DW'(cc) - DW'(rc);
            half_in[i]     = ref_half_reg[i*C +: C];
            half_in[3 + i] = s_axis_tdata[HLF_LO + i*C +: C];
            for (int c = 0; c < 3; c++)
            begin
                ax_in[i][c]     = ref_axis_reg[i][c*A +: A];
                ax_in[3 + i][c] = s_axis_tdata[AX_LO + i*3*A + c*A +: A];
            end
        end
        if (flat_in)
        begin
            d_in[2] = '0;
            half_in[2] = '0;
            half_in[5] = '0;
            for (int k = 0; k < 6; k++)
            begin
                ax_in[k][2] = '0;
            end
        end
    end

    // shared operand pipeline
    logic signed [DW-1:0] d_s1_reg [3];
    logic signed [DW-1:0] d_s2_reg [3];
    logic signed [A-1:0]  ax_s1_reg [6][3];
    logic signed [A-1:0]  ax_s2_reg [6][3];
    logic        [C-1:0]  half_s1_reg [6];
    logic        [C-1:0]  half_s2_reg [6];
    logic        [C-1:0]  half_s3_reg [6];
    logic        [C-1:0]  half_s4_reg [6];
    logic [NST-1:1]       flat_reg;
    logic                 overlap_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.adv[1])
        begin
            d_s1_reg    <= d_in;
            ax_s1_reg   <= ax_in;
            half_s1_reg <= half_in;
            flat_reg[1] <= flat_in;
        end
        if (ctl.adv[2])
        begin
            d_s2_reg    <= d_s1_reg;
            ax_s2_reg   <= ax_s1_reg;
            half_s2_reg <= half_s1_reg;
            flat_reg[2] <= flat_reg[1];
        end
        if (ctl.adv[3])
        begin
            half_s3_reg <= half_s2_reg;
            flat_reg[3] <= flat_reg[2];
        end
        if (ctl.adv[4])
        begin
            half_s4_reg <= half_s3_reg;
            flat_reg[4] <= flat_reg[3];
        end
        if (ctl.adv[5])
            flat_reg[5] <= flat_reg[4];
        if (ctl.adv[6])
            flat_reg[6] <= flat_reg[5];
    end

    // test axes: faces first, then reference i x candidate j
    logic signed [PW-1:0] p_ax [NAX][3];
    logic [NAX-1:0]       sep;

    for (genvar k = 0; k < 6; k++)
    begin : g_face
        for (genvar c = 0; c < 3; c++)
        begin : g_comp
            assign p_ax[k][c] = PW'(ax_s2_reg[k][c]);
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_ref
        for (genvar j = 0; j < 3; j++)
        begin : g_cand
            obb_cross #(
                .AXIS_WIDTH (AXIS_WIDTH)
            ) u_cross (
                .clk (clk),
                .ctl (ctl),
                .a   (ax_in[i]),
                .b   (ax_in[3 + j]),
                .p   (p_ax[6 + 3*i + j])
            );
        end
    end

    for (genvar l = 0; l < NAX; l++)
    begin : g_lane
        obb_axis #(
            .COORD_WIDTH (COORD_WIDTH),
            .AXIS_WIDTH  (AXIS_WIDTH)
        ) u_axis (
            .clk  (clk),
            .ctl  (ctl),
            .p    (p_ax[l]),
            .d    (d_s2_reg),
            .ax   (ax_s2_reg),
            .half (half_s4_reg),
            .sep  (sep[l])
        );
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv[NST])
        begin
            overlap_reg <= ~|(sep & (flat_reg[6] ? obb_pkg::MASK_2D : obb_pkg::MASK_3D));
        end
    end

    assign m_axis_tvalid = valid_reg[NST];
    assign m_axis_tdata  = {{(obb_pkg::OUT_W - 1){1'b0}}, overlap_reg};

endmodule

FILE: hdl/obb_cross.sv
// Cross product of a reference and a candidate axis, rounded to axis format.
// Stages 1 (partial products) and 2 (difference and round). Uses obb_pkg.
module obb_cross #(
    parameter int AXIS_WIDTH = obb_pkg::AXIS_WIDTH
) (
    input  logic                             clk,
    input  obb_pkg::obb_ctl_t                ctl,
    input  logic signed [AXIS_WIDTH-1:0]     a [3],
    input  logic signed [AXIS_WIDTH-1:0]     b [3],
    output logic signed [AXIS_WIDTH+2:0]     p [3]
);
    localparam int A  = AXIS_WIDTH;
    localparam int F  = A - 2;
    localparam int PW = A + 3;
    localparam int MW = 2 * A;
    localparam int RW = 2 * A + 1;
    localparam logic signed [RW-1:0] RND = RW'(1) <<< (F - 1);

    logic signed [MW-1:0] m1_reg [3];
    logic signed [MW-1:0] m2_reg [3];
    logic signed [PW-1:0] p_reg [3];
    logic signed [RW-1:0] rsh [3];

    always_ff @(posedge clk)
    begin
        if (ctl.adv[1])
        begin
            for (int c = 0; c < 3; c++)
            begin
                m1_reg[c] <= MW'(a[(c + 1) % 3]) * MW'(b[(c + 2) % 3]);
                m2_reg[c] <= MW'(a[(c + 2) % 3]) * MW'(b[(c + 1) % 3]);
            end
        end
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            rsh[c] = (RW'(m1_reg[c]) - RW'(m2_reg[c]) + RND) >>> F;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv[2])
        begin
            for (int c = 0; c < 3; c++)
            begin
                p_reg[c] <= rsh[c][PW-1:0];
            end
        end
    end

    assign p = p_reg;

endmodule

FILE: hdl/obb_axis.sv
// One separating axis test lane: projections, rounding, weighted sum, compare.
// Stages 3 to 6. Uses obb_pkg.
module obb_axis #(
    parameter int COORD_WIDTH = obb_pkg::COORD_WIDTH,
    parameter int AXIS_WIDTH  = obb_pkg::AXIS_WIDTH
) (
    input  logic                          clk,
    input  obb_pkg::obb_ctl_t             ctl,
    input  logic signed [AXIS_WIDTH+2:0]  p [3],
    input  logic signed [COORD_WIDTH:0]   d [3],
    input  logic signed [AXIS_WIDTH-1:0]  ax [6][3],
    input  logic        [COORD_WIDTH-1:0] half [6],
    output logic                          sep
);
    localparam int C    = COORD_WIDTH;
    localparam int A    = AXIS_WIDTH;
    localparam int F    = A - 2;
    localparam int PW   = A + 3;
    localparam int DW   = C + 1;
    localparam int DPW  = DW + PW;
    localparam int DSW  = DPW + 2;
    localparam int APW  = A + PW;
    localparam int ASW  = APW + 2;
    localparam int AMW  = ASW + 1;
    localparam int PJW  = AMW - F;
    localparam int TW   = C + PJW;
    localparam int RSW  = TW + 3;
    localparam int CMPW = (RSW > DSW) ? RSW : DSW;
    localparam logic [AMW-1:0] RND = AMW'(1) << (F - 1);

    logic signed [DPW-1:0] dp_reg [3];
    logic signed [APW-1:0] ap_reg [6][3];
    logic        [DSW-1:0] lhs4_reg;
    logic        [DSW-1:0] lhs5_reg;
    logic        [PJW-1:0] proj_reg [6];
    logic        [TW-1:0]  term_reg [6];
    logic                  sep_reg;

    logic signed [DSW-1:0] dsum;
    logic        [DSW-1:0] lhs_next;
    logic signed [ASW-1:0] asum [6];
    logic        [AMW-1:0] amag [6];
    logic        [PJW-1:0] proj_next [6];
    logic        [RSW-1:0] rsum;

    always_ff @(posedge clk)
    begin
        if (ctl.adv[3])
        begin
            for (int c = 0; c < 3; c++)
            begin
                dp_reg[c] <= DPW'(d[c]) * DPW'(p[c]);
                for (int k = 0; k < 6; k++)
                begin
                    ap_reg[k][c] <= APW'(ax[k][c]) * APW'(p[c]);
                end
            end
        end
    end

    always_comb
    begin
        dsum = DSW'(dp_reg[0]) + DSW'(dp_reg[1]) + DSW'(dp_reg[2]);
        lhs_next = dsum[DSW-1] ? DSW'(-dsum) : DSW'(dsum);
        for (int k = 0; k < 6; k++)
        begin
            asum[k] = ASW'(ap_reg[k][0]) + ASW'(ap_reg[k][1]) + ASW'(ap_reg[k][2]);
            amag[k] = asum[k][ASW-1] ? AMW'(-asum[k]) : AMW'(asum[k]);
            proj_next[k] = PJW'((amag[k] + RND) >> F);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv[4])
        begin
            lhs4_reg <= lhs_next;
            proj_reg <= proj_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv[5])
        begin
            lhs5_reg <= lhs4_reg;
            for (int k = 0; k < 6; k++)
            begin
                term_reg[k] <= TW'(half[k]) * TW'(proj_reg[k]);
            end
        end
    end

    always_comb
    begin
        rsum = '0;
        for (int k = 0; k < 6; k++)
        begin
            rsum = rsum + RSW'(term_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.adv[6])
        begin
            sep_reg <= CMPW'(lhs5_reg) > CMPW'(rsum);
        end
    end

    assign sep = sep_reg;

endmodule

FILE: hdl/obb_sat_checker.sv
// Port-level checks for obb_separating_axis_overlap, bound to the top level.
// Depends on obb_pkg and obb_separating_axis_overlap_assert.svh.
`include "obb_separating_axis_overlap_assert.svh"

module obb_sat_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [obb_pkg::OUT_W-1:0]   m_axis_tdata
);

    `OBB_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
    `OBB_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed while stalled")
    `OBB_ASSERT(a_flow, m_axis_tready |-> s_axis_tready, "request side blocked while result side drains")
    `OBB_ASSERT_RST(a_reset, !rst_n |=> !m_axis_tvalid, "result shown after reset")

endmodule

bind obb_separating_axis_overlap obb_sat_checker u_obb_sat_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
